@@ rtl/mtnp_pkg.sv @@
// Package for the MIDI track note event parser.
// Holds the word types of both channels, the queue entry type and shared codes.
// No dependencies.
package mtnp_pkg;

    localparam int VLQ_MAX_BYTES_DEFAULT = 4;
    localparam int TICK_WIDTH_DEFAULT    = 64;
    localparam int QUEUE_DEPTH_DEFAULT   = 4;

    localparam int DELTA_W = 28;
    localparam int ABS_W   = 64;

    localparam logic [1:0] KIND_NOTE  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_word_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic               note_on;
        logic [3:0]         channel;
        logic [6:0]         note_key;
        logic [6:0]         velocity;
        logic [DELTA_W-1:0] delta_time;
        logic [ABS_W-1:0]   tick_stamp;
        logic               last_of_run;
    } event_word_t;

    // One entry per input byte that gives results.
    typedef struct packed {
        logic               emit_note;
        logic               emit_end;
        logic               emit_err;
        logic               note_on;
        logic [3:0]         channel;
        logic [6:0]         note_key;
        logic [6:0]         velocity;
        logic [DELTA_W-1:0] delta_time;
        logic [ABS_W-1:0]   tick_stamp;
    } cmd_t;

endpackage

@@ rtl/mtnp_front.sv @@
// Front end of the MIDI track note event parser: byte-level parse state machine.
// Classifies each accepted byte into a queue entry. Depends on mtnp_pkg.
module mtnp_front
    import mtnp_pkg::*;
#(
    parameter int VLQ_MAX_BYTES = VLQ_MAX_BYTES_DEFAULT,
    parameter int TICK_WIDTH    = TICK_WIDTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  byte_word_t byte_word,
    input  logic       queue_full,
    output logic       byte_stall,
    output logic       push,
    output cmd_t       push_cmd
);

    localparam int CNT_W = $clog2(VLQ_MAX_BYTES + 1);

    localparam logic [2:0] PH_DELTA     = 3'd0;
    localparam logic [2:0] PH_STATUS    = 3'd1;
    localparam logic [2:0] PH_META_TYPE = 3'd2;
    localparam logic [2:0] PH_LENGTH    = 3'd3;
    localparam logic [2:0] PH_SKIP      = 3'd4;
    localparam logic [2:0] PH_DATA1     = 3'd5;
    localparam logic [2:0] PH_DATA2     = 3'd6;
    localparam logic [2:0] PH_FAULT     = 3'd7;

    localparam logic [7:0] STATUS_SYSEX  = 8'hF0;
    localparam logic [7:0] STATUS_ESCAPE = 8'hF7;
    localparam logic [7:0] STATUS_META   = 8'hFF;
    localparam logic [3:0] HI_NOTE_OFF   = 4'h8;
    localparam logic [3:0] HI_NOTE_ON    = 4'h9;
    localparam logic [3:0] HI_PROGRAM    = 4'hC;
    localparam logic [3:0] HI_PRESSURE   = 4'hD;
    localparam logic [3:0] HI_SYSTEM     = 4'hF;

    logic [2:0]            phase_reg, phase_next;
    logic [DELTA_W-1:0]    vlq_reg, vlq_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DELTA_W-1:0]    held_reg, held_next;
    logic [TICK_WIDTH-1:0] tick_reg, tick_next;
    logic [7:0]            run_status_reg, run_status_next;
    logic [7:0]            cur_status_reg, cur_status_next;
    logic [7:0]            first_reg, first_next;
    logic [DELTA_W-1:0]    skip_reg, skip_next;

    logic                  accept;
    logic [7:0]            b;
    logic [DELTA_W-1:0]    vlq_shift;
    logic [CNT_W-1:0]      vlq_inc;
    logic                  vlq_over;
    logic [TICK_WIDTH:0]   sum;
    logic [DELTA_W-1:0]    skip_dec;
    logic                  fault;
    logic                  in_fault;
    logic                  take;
    logic [7:0]            d1_status;
    logic                  fin;
    logic [7:0]            fin_status;
    logic [7:0]            fin_first;
    logic [7:0]            fin_second;
    logic                  end_ok;
    cmd_t                  cmd;

    assign byte_stall = queue_full;
    assign accept     = byte_valid && !queue_full;
    assign b          = byte_word.data_byte;

    always_comb
    begin
        phase_next      = phase_reg;
        vlq_next        = vlq_reg;
        cnt_next        = cnt_reg;
        held_next       = held_reg;
        tick_next       = tick_reg;
        run_status_next = run_status_reg;
        cur_status_next = cur_status_reg;
        first_next      = first_reg;
        skip_next       = skip_reg;
        fault           = 1'b0;
        take            = 1'b0;
        d1_status       = cur_status_reg;
        fin             = 1'b0;
        fin_status      = cur_status_reg;
        fin_first       = first_reg;
        fin_second      = 8'h00;
        in_fault        = (phase_reg == PH_FAULT);

        vlq_shift = {vlq_reg[DELTA_W-8:0], b[6:0]};
        vlq_inc   = cnt_reg + CNT_W'(1);
        vlq_over  = b[7] && (vlq_inc >= CNT_W'(VLQ_MAX_BYTES));
        sum       = {1'b0, tick_reg} + {1'b0, TICK_WIDTH'(vlq_shift)};
        skip_dec  = skip_reg - DELTA_W'(1);

        case (phase_reg)
            PH_DELTA:
            begin
                vlq_next = vlq_shift;
                cnt_next = vlq_inc;
                if (vlq_over)
                begin
                    fault = 1'b1;
                end
                else if (!b[7])
                begin
                    if (sum[TICK_WIDTH])
                    begin
                        fault = 1'b1;
                    end
                    else
                    begin
                        tick_next  = sum[TICK_WIDTH-1:0];
                        held_next  = vlq_shift;
                        vlq_next   = '0;
                        cnt_next   = '0;
                        phase_next = PH_STATUS;
                    end
                end
            end
            PH_STATUS:
            begin
                if (!b[7])
                begin
                    if (run_status_reg == 8'h00)
                    begin
                        fault = 1'b1;
                    end
                    else
                    begin
                        cur_status_next = run_status_reg;
                        d1_status       = run_status_reg;
                        take            = 1'b1;
                    end
                end
                else
                begin
                    cur_status_next = b;
                    if (b[7:4] != HI_SYSTEM)
                    begin
                        run_status_next = b;
                        phase_next      = PH_DATA1;
                    end
                    else if (b == STATUS_META)
                    begin
                        run_status_next = 8'h00;
                        phase_next      = PH_META_TYPE;
                    end
                    else if (b inside {STATUS_SYSEX, STATUS_ESCAPE})
                    begin
                        run_status_next = 8'h00;
                        phase_next      = PH_LENGTH;
                    end
                    else
                    begin
                        fault = 1'b1;
                    end
                end
            end
            PH_META_TYPE:
            begin
                phase_next = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                vlq_next = vlq_shift;
                cnt_next = vlq_inc;
                if (vlq_over)
                begin
                    fault = 1'b1;
                end
                else if (!b[7])
                begin
                    skip_next  = vlq_shift;
                    vlq_next   = '0;
                    cnt_next   = '0;
                    phase_next = (vlq_shift == '0) ? PH_DELTA : PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == '0)
                begin
                    phase_next = PH_DELTA;
                end
            end
            PH_DATA1:
            begin
                if (b[7])
                begin
                    fault = 1'b1;
                end
                else
                begin
                    take = 1'b1;
                end
            end
            PH_DATA2:
            begin
                if (b[7])
                begin
                    fault = 1'b1;
                end
                else
                begin
                    fin        = 1'b1;
                    fin_second = b;
                end
            end
            PH_FAULT:
            begin
                phase_next = PH_FAULT;
            end
            default:
            begin
                fault = 1'b1;
            end
        endcase

        if (take)
        begin
            first_next = b;
            if (d1_status[7:4] inside {HI_PROGRAM, HI_PRESSURE})
            begin
                fin        = 1'b1;
                fin_status = d1_status;
                fin_first  = b;
                fin_second = 8'h00;
            end
            else
            begin
                phase_next = PH_DATA2;
            end
        end

        if (fin)
        begin
            phase_next = PH_DELTA;
        end

        if (fault)
        begin
            phase_next = PH_FAULT;
        end

        end_ok = (phase_next == PH_DELTA) && (cnt_next == '0);

        cmd             = '0;
        cmd.emit_note   = fin && (fin_status[7:4] inside {HI_NOTE_OFF, HI_NOTE_ON});
        cmd.note_on     = (fin_status[7:4] == HI_NOTE_ON) && (fin_second != 8'h00);
        cmd.channel     = fin_status[3:0];
        cmd.note_key    = fin_first[6:0];
        cmd.velocity    = fin_second[6:0];
        cmd.delta_time  = held_reg;
        cmd.tick_stamp  = ABS_W'(tick_next);
        cmd.emit_err    = fault;

        if (byte_word.last_byte)
        begin
            cmd.emit_end    = !fault && !in_fault && end_ok;
            cmd.emit_err    = fault || (!in_fault && !end_ok);
            phase_next      = PH_DELTA;
            vlq_next        = '0;
            cnt_next        = '0;
            held_next       = '0;
            tick_next       = '0;
            run_status_next = 8'h00;
            cur_status_next = 8'h00;
            first_next      = 8'h00;
            skip_next       = '0;
        end
    end

    assign push     = accept && (cmd.emit_note || cmd.emit_end || cmd.emit_err);
    assign push_cmd = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_DELTA;
            vlq_reg        <= '0;
            cnt_reg        <= '0;
            held_reg       <= '0;
            tick_reg       <= '0;
            run_status_reg <= 8'h00;
            cur_status_reg <= 8'h00;
            first_reg      <= 8'h00;
            skip_reg       <= '0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            vlq_reg        <= vlq_next;
            cnt_reg        <= cnt_next;
            held_reg       <= held_next;
            tick_reg       <= tick_next;
            run_status_reg <= run_status_next;
            cur_status_reg <= cur_status_next;
            first_reg      <= first_next;
            skip_reg       <= skip_next;
        end
    end

endmodule

@@ rtl/mtnp_queue.sv @@
// Short first-in first-out queue between the parser front end and back end.
// Entries are of type cmd_t. Depends on mtnp_pkg.
module mtnp_queue
    import mtnp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic empty,
    output cmd_t head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/mtnp_back.sv @@
// Back end of the MIDI track note event parser: expands queue entries into
// result words and holds them in the output register. Depends on mtnp_pkg.
module mtnp_back
    import mtnp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        empty,
    input  cmd_t        head,
    output logic        pop,
    output logic        event_valid,
    input  logic        event_stall,
    output event_word_t event_word
);

    logic        valid_reg, valid_next;
    event_word_t word_reg, word_next;
    logic        second_reg, second_next;
    logic        load;
    event_word_t note_word;
    event_word_t end_word;
    event_word_t err_word;

    assign load = !valid_reg || !event_stall;

    always_comb
    begin
        note_word             = '0;
        note_word.kind        = KIND_NOTE;
        note_word.note_on     = head.note_on;
        note_word.channel     = head.channel;
        note_word.note_key    = head.note_key;
        note_word.velocity    = head.velocity;
        note_word.delta_time  = head.delta_time;
        note_word.tick_stamp  = head.tick_stamp;
        note_word.last_of_run = 1'b1;

        end_word             = '0;
        end_word.kind        = KIND_END;
        end_word.tick_stamp  = head.tick_stamp;
        end_word.last_of_run = 1'b1;

        err_word             = '0;
        err_word.kind        = KIND_ERROR;
        err_word.last_of_run = 1'b1;

        valid_next  = valid_reg;
        word_next   = word_reg;
        second_next = second_reg;
        pop         = 1'b0;

        if (load)
        begin
            valid_next = !empty;
            if (!empty)
            begin
                if (second_reg)
                begin
                    word_next   = end_word;
                    second_next = 1'b0;
                    pop         = 1'b1;
                end
                else if (head.emit_note && head.emit_end)
                begin
                    word_next             = note_word;
                    word_next.last_of_run = 1'b0;
                    second_next           = 1'b1;
                end
                else
                begin
                    if (head.emit_note)
                    begin
                        word_next = note_word;
                    end
                    else if (head.emit_end)
                    begin
                        word_next = end_word;
                    end
                    else
                    begin
                        word_next = err_word;
                    end
                    pop = 1'b1;
                end
            end
        end
    end

    assign event_valid = valid_reg;
    assign event_word  = word_reg;

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

endmodule

@@ rtl/midi_track_note_event_parser_core.sv @@
// Top level of the MIDI track note event parser.
// Instantiates mtnp_front, mtnp_queue and mtnp_back. Depends on mtnp_pkg.
//
// The byte channel (byte_valid, byte_stall, byte_word) takes one word per cycle
// while byte_stall is low: one byte of a track chunk body and a flag marking
// its final byte. A word is taken at a rising edge where byte_valid is high and
// byte_stall is low. The event channel (event_valid, event_stall, event_word)
// gives note-on and note-off events, the track end tick on the final byte, and
// a single error word for a malformed track, with last_of_run set on the final
// word of a byte. Each byte is parsed in the cycle it is taken; its results
// enter a queue of QUEUE_DEPTH entries and from there the output register.
// The parser takes one byte per cycle while the queue is not full; a byte that
// gives both a note event and the track end yields the note word, then the end
// word. The rate is set by the combinational parse step, whose longest path is
// the tick add with its overflow carry.
// byte_stall rises only when the queue is full, which happens when the receiver
// holds event_stall high. Reset empties the queue and the output register and
// returns the parser to the start of a delta time with a zero tick count.
module midi_track_note_event_parser_core
    import mtnp_pkg::*;
#(
    parameter int VLQ_MAX_BYTES = VLQ_MAX_BYTES_DEFAULT,
    parameter int TICK_WIDTH    = TICK_WIDTH_DEFAULT,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  byte_word_t  byte_word,
    output logic        event_valid,
    input  logic        event_stall,
    output event_word_t event_word
);

    logic push;
    cmd_t push_cmd;
    logic pop;
    logic full;
    logic empty;
    cmd_t head;

    mtnp_front #(
        .VLQ_MAX_BYTES (VLQ_MAX_BYTES),
        .TICK_WIDTH    (TICK_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_word  (byte_word),
        .queue_full (full),
        .byte_stall (byte_stall),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    mtnp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (full),
        .empty    (empty),
        .head     (head)
    );

    mtnp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (empty),
        .head        (head),
        .pop         (pop),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .event_word  (event_word)
    );

endmodule

@@ bench/midi_track_note_event_parser_core_tb.sv @@
`timescale 1ns / 100ps
// Testbench for midi_track_note_event_parser_core: feeds track chunk bytes with random
// idling and checks every event word against a behavioural model of the parser.
// Depends on mtnp_pkg and the parser RTL.
module midi_track_note_event_parser_core_tb;
    import mtnp_pkg::*;

    typedef enum logic [3:0] {
        PH_DELTA,
        PH_STATUS,
        PH_META_TYPE,
        PH_LENGTH,
        PH_SKIP,
        PH_DATA1,
        PH_DATA2,
        PH_FAULT
    } parse_phase_t;

    localparam int VLQ_BYTES    = 4;
    localparam int RANDOM_BYTES = 1100;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int QUIET_FROM   = 800;
    localparam int QUIET_TO     = 2000;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_LEN     = 400;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [3:0] HI_NOTE_OFF = 4'h8;
    localparam logic [3:0] HI_NOTE_ON  = 4'h9;
    localparam logic [3:0] HI_POLY     = 4'hA;
    localparam logic [3:0] HI_PROGRAM  = 4'hC;
    localparam logic [3:0] HI_PRESSURE = 4'hD;
    localparam logic [3:0] HI_BEND     = 4'hE;
    localparam logic [7:0] ST_SYSEX     = 8'hF0;
    localparam logic [7:0] ST_UNDEFINED = 8'hF1;
    localparam logic [7:0] ST_ESCAPE    = 8'hF7;
    localparam logic [7:0] ST_META      = 8'hFF;
    localparam logic [7:0] META_TEXT    = 8'h01;
    localparam logic [7:0] META_END     = 8'h2F;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    byte_word_t  byte_word = '0;
    logic        event_valid;
    logic        event_stall = 1'b0;
    event_word_t event_word;

    byte_word_t  pending_bytes[$];
    event_word_t expected_events[$];
    logic [7:0]  track_bytes[$];
    int          cycle = 0;
    int          hold_left = 0;
    int          mismatches = 0;

    parse_phase_t parse_ph;
    logic [27:0]  vlq_acc;
    logic [2:0]   vlq_cnt;
    logic [27:0]  held_delta;
    logic [63:0]  tick_total;
    logic [7:0]   run_status;
    logic [7:0]   cur_status;
    logic [7:0]   first_data;
    logic [27:0]  skip_left;

    midi_track_note_event_parser_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .byte_word   (byte_word),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .event_word  (event_word)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic reset_parser();
        parse_ph   = PH_DELTA;
        vlq_acc    = '0;
        vlq_cnt    = '0;
        held_delta = '0;
        tick_total = '0;
        run_status = '0;
        cur_status = '0;
        first_data = '0;
        skip_left  = '0;
    endtask

    function automatic int vlq_take(input logic [7:0] b);
        vlq_acc = {vlq_acc[20:0], b[6:0]};
        vlq_cnt = vlq_cnt + 3'd1;
        if (!b[7])
            return 1;
        if (vlq_cnt >= VLQ_BYTES)
            return -1;
        return 0;
    endfunction

    function automatic event_word_t make_word(input logic [1:0] kind, input logic on,
                                              input logic [3:0] ch, input logic [6:0] note,
                                              input logic [6:0] vel, input logic [27:0] delta,
                                              input logic [63:0] abs_tick);
        event_word_t w;
        w.kind        = kind;
        w.note_on     = on;
        w.channel     = ch;
        w.note_key    = note;
        w.velocity    = vel;
        w.delta_time  = delta;
        w.tick_stamp  = abs_tick;
        w.last_of_run = 1'b0;
        return w;
    endfunction

    task automatic predict_events(input byte_word_t w);
        event_word_t got[$];
        logic [7:0]  b;
        logic [7:0]  second;
        logic [3:0]  hi;
        logic        fault;
        logic        reported;
        logic        take1;
        logic        done;
        int          vr;
        b        = w.data_byte;
        second   = '0;
        fault    = 1'b0;
        reported = 1'b0;
        take1    = 1'b0;
        done     = 1'b0;
        if (parse_ph != PH_FAULT)
        begin
            case (parse_ph)
                PH_DELTA:
                begin
                    vr = vlq_take(b);
                    if (vr < 0)
                        fault = 1'b1;
                    else if (vr > 0)
                    begin
                        if ({36'd0, vlq_acc} > (~64'd0 - tick_total))
                            fault = 1'b1;
                        else
                        begin
                            tick_total = tick_total + {36'd0, vlq_acc};
                            held_delta = vlq_acc;
                            vlq_acc    = '0;
                            vlq_cnt    = '0;
                            parse_ph   = PH_STATUS;
                        end
                    end
                end
                PH_STATUS:
                begin
                    if (!b[7])
                    begin
                        if (run_status == 8'd0)
                            fault = 1'b1;
                        else
                        begin
                            cur_status = run_status;
                            take1      = 1'b1;
                        end
                    end
                    else
                    begin
                        cur_status = b;
                        if (b < ST_SYSEX)
                        begin
                            run_status = b;
                            parse_ph   = PH_DATA1;
                        end
                        else if (b == ST_META)
                        begin
                            run_status = '0;
                            parse_ph   = PH_META_TYPE;
                        end
                        else if (b == ST_SYSEX || b == ST_ESCAPE)
                        begin
                            run_status = '0;
                            parse_ph   = PH_LENGTH;
                        end
                        else
                            fault = 1'b1;
                    end
                end
                PH_META_TYPE:
                    parse_ph = PH_LENGTH;
                PH_LENGTH:
                begin
                    vr = vlq_take(b);
                    if (vr < 0)
                        fault = 1'b1;
                    else if (vr > 0)
                    begin
                        skip_left = vlq_acc;
                        vlq_acc   = '0;
                        vlq_cnt   = '0;
                        parse_ph  = (skip_left == 28'd0) ? PH_DELTA : PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    skip_left = skip_left - 28'd1;
                    if (skip_left == 28'd0)
                        parse_ph = PH_DELTA;
                end
                PH_DATA1:
                    take1 = 1'b1;
                PH_DATA2:
                begin
                    if (b[7])
                        fault = 1'b1;
                    else
                    begin
                        second = b;
                        done   = 1'b1;
                    end
                end
                default:
                    fault = 1'b1;
            endcase
            hi = cur_status[7:4];
            if (take1)
            begin
                if (b[7])
                    fault = 1'b1;
                else
                begin
                    first_data = b;
                    if (hi == HI_PROGRAM || hi == HI_PRESSURE)
                        done = 1'b1;
                    else
                        parse_ph = PH_DATA2;
                end
            end
            if (done)
            begin
                if (hi == HI_NOTE_ON || hi == HI_NOTE_OFF)
                    got.push_back(make_word(KIND_NOTE, hi == HI_NOTE_ON && second != 8'd0,
                                            cur_status[3:0], first_data[6:0], second[6:0],
                                            held_delta, tick_total));
                parse_ph = PH_DELTA;
            end
            if (fault)
            begin
                parse_ph = PH_FAULT;
                got.push_back(make_word(KIND_ERROR, 1'b0, '0, '0, '0, '0, '0));
                reported = 1'b1;
            end
        end
        if (w.last_byte)
        begin
            if (!reported && parse_ph != PH_FAULT)
            begin
                if (parse_ph == PH_DELTA && vlq_cnt == 3'd0)
                    got.push_back(make_word(KIND_END, 1'b0, '0, '0, '0, '0, tick_total));
                else
                    got.push_back(make_word(KIND_ERROR, 1'b0, '0, '0, '0, '0, '0));
            end
            reset_parser();
        end
        if (got.size() != 0)
            got[got.size() - 1].last_of_run = 1'b1;
        foreach (got[i])
            expected_events.push_back(got[i]);
    endtask

    task automatic push_vlq(input logic [27:0] value, input int nb);
        for (int i = nb - 1; i >= 0; i--)
            track_bytes.push_back({i != 0, 7'(value >> (7 * i))});
    endtask

    task automatic add_delta();
        int nb;
        int roll;
        roll = $urandom_range(99);
        nb = (roll < 70) ? 1 : (roll < 85) ? 2 : (roll < 95) ? 3 : 4;
        push_vlq(28'($urandom_range(0, (1 << (7 * nb)) - 1)), nb);
    endtask

    task automatic flush_track();
        byte_word_t bw;
        foreach (track_bytes[i])
        begin
            bw.data_byte = track_bytes[i];
            bw.last_byte = (i == track_bytes.size() - 1);
            pending_bytes.push_back(bw);
        end
        track_bytes.delete();
    endtask

    task automatic gen_track();
        int         event_count;
        int         roll;
        int         len;
        int         keep;
        logic [7:0] status;
        logic [7:0] last_status;
        logic       have_run;
        track_bytes.delete();
        if ($urandom_range(99) < 5)
        begin
            repeat ($urandom_range(1, 16))
                track_bytes.push_back(8'($urandom_range(255)));
        end
        else
        begin
            have_run    = 1'b0;
            last_status = '0;
            event_count = $urandom_range(1, 10);
            for (int e = 0; e < event_count; e++)
            begin
                add_delta();
                roll = $urandom_range(99);
                if (roll < 60)
                begin
                    if (have_run && $urandom_range(1) == 1)
                        status = last_status;
                    else
                    begin
                        if (roll < 45)
                            status = {($urandom_range(3) != 0) ? HI_NOTE_ON : HI_NOTE_OFF,
                                      4'($urandom_range(15))};
                        else
                            status = {4'($urandom_range(HI_POLY, HI_BEND)),
                                      4'($urandom_range(15))};
                        track_bytes.push_back(status);
                    end
                    last_status = status;
                    have_run    = 1'b1;
                    track_bytes.push_back(8'($urandom_range(127)));
                    if (status[7:4] != HI_PROGRAM && status[7:4] != HI_PRESSURE)
                        track_bytes.push_back(($urandom_range(4) == 0) ? 8'd0
                                              : 8'($urandom_range(127)));
                end
                else
                begin
                    status = (roll < 80) ? ST_META
                             : ($urandom_range(1) == 1) ? ST_SYSEX : ST_ESCAPE;
                    track_bytes.push_back(status);
                    if (status == ST_META)
                        track_bytes.push_back(8'($urandom_range(255)));
                    len = ($urandom_range(19) == 0) ? $urandom_range(128, 140)
                          : $urandom_range(0, 4);
                    push_vlq(28'(len), (len > 127) ? 2 : $urandom_range(1, 2));
                    repeat (len)
                        track_bytes.push_back(8'($urandom_range(255)));
                    have_run = 1'b0;
                end
            end
            if ($urandom_range(99) < 60)
            begin
                add_delta();
                track_bytes.push_back(ST_META);
                track_bytes.push_back(META_END);
                track_bytes.push_back(8'd0);
            end
            if ($urandom_range(99) < 15)
            begin
                if ($urandom_range(1) == 1)
                    track_bytes[$urandom_range(track_bytes.size() - 1)] = 8'($urandom_range(255));
                else
                begin
                    keep = $urandom_range(1, track_bytes.size());
                    while (track_bytes.size() > keep)
                        void'(track_bytes.pop_back());
                end
            end
        end
        flush_track();
    endtask

    function automatic logic idle_now();
        if (cycle >= QUIET_FROM && cycle < QUIET_TO)
            return 1'b0;
        return $urandom_range(99) < 38;
    endfunction

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle >= CYCLE_LIMIT)
        begin
            $display("[midi_track_note_event_parser_core] ERROR");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_word  <= '0;
        end
        else
        begin
            if (byte_valid && !byte_stall)
                predict_events(byte_word);
            if (!byte_valid || !byte_stall)
            begin
                if (pending_bytes.size() != 0 && !idle_now())
                begin
                    byte_valid <= 1'b1;
                    byte_word  <= pending_bytes.pop_front();
                end
                else
                    byte_valid <= 1'b0;
            end
        end
    end

    // The receiver holds off once for a long stretch so that the queue fills.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            event_stall <= 1'b0;
            hold_left   <= 0;
        end
        else if (hold_left != 0)
        begin
            event_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end
        else if (cycle == HOLD_AT)
        begin
            event_stall <= 1'b1;
            hold_left   <= HOLD_LEN;
        end
        else
            event_stall <= idle_now();
    end

    always @(posedge clk)
    begin : event_monitor
        event_word_t want;
        if (rst_n && event_valid && !event_stall)
        begin
            if (expected_events.size() == 0)
            begin
                $error("unexpected event word: kind %0d tick_stamp %0d",
                       event_word.kind, event_word.tick_stamp);
                mismatches++;
            end
            else
            begin
                want = expected_events.pop_front();
                if (event_word.kind !== want.kind)
                begin
                    $error("kind: expected %0d, actual %0d", want.kind, event_word.kind);
                    mismatches++;
                end
                if (event_word.note_on !== want.note_on)
                begin
                    $error("note_on: expected %0d, actual %0d", want.note_on, event_word.note_on);
                    mismatches++;
                end
                if (event_word.channel !== want.channel)
                begin
                    $error("channel: expected %0d, actual %0d", want.channel, event_word.channel);
                    mismatches++;
                end
                if (event_word.note_key !== want.note_key)
                begin
                    $error("note_key: expected %0d, actual %0d",
                           want.note_key, event_word.note_key);
                    mismatches++;
                end
                if (event_word.velocity !== want.velocity)
                begin
                    $error("velocity: expected %0d, actual %0d",
                           want.velocity, event_word.velocity);
                    mismatches++;
                end
                if (event_word.delta_time !== want.delta_time)
                begin
                    $error("delta_time: expected %0d, actual %0d",
                           want.delta_time, event_word.delta_time);
                    mismatches++;
                end
                if (event_word.tick_stamp !== want.tick_stamp)
                begin
                    $error("tick_stamp: expected %0d, actual %0d",
                           want.tick_stamp, event_word.tick_stamp);
                    mismatches++;
                end
                if (event_word.last_of_run !== want.last_of_run)
                begin
                    $error("last_of_run: expected %0d, actual %0d",
                           want.last_of_run, event_word.last_of_run);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int directed_count;
        reset_parser();
        // Longest delta, running status with zero velocity, meta skip, program change,
        // and a note completed by the final byte of the track.
        track_bytes = '{8'h8F, 8'hFF, 8'hFF, 8'h7F, {HI_NOTE_ON, 4'hF}, 8'h7F, 8'h7F,
                        8'h00, 8'h00, 8'h00,
                        8'h00, ST_META, META_TEXT, 8'h02, 8'h80, 8'h41,
                        8'h00, {HI_PROGRAM, 4'h3}, 8'h05,
                        8'h00, {HI_NOTE_OFF, 4'h0}, 8'h01, 8'h02};
        flush_track();
        track_bytes = '{8'h00, ST_UNDEFINED};
        flush_track();
        track_bytes = '{8'h80, 8'h80, 8'h80, 8'h80};
        flush_track();
        track_bytes = '{8'h00, 8'h40};
        flush_track();
        track_bytes = '{8'h05};
        flush_track();
        directed_count = pending_bytes.size();
        while (pending_bytes.size() < directed_count + RANDOM_BYTES)
            gen_track();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_bytes.size() != 0 || byte_valid)
            @(posedge clk);
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[midi_track_note_event_parser_core] OK");
        else
            $display("[midi_track_note_event_parser_core] ERROR");
        $finish;
    end

endmodule
